// ----- design/b2bcd_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package b2bcd_pkg;

   localparam int DIGIT_BITS = 4;
   localparam int BYTE_BITS  = 8;
   localparam int INDEX_BITS = 3;
   localparam int COUNT_BITS = 4;

   typedef logic [DIGIT_BITS-1:0] digit_type;

   typedef struct packed {
      logic clear;
      logic shift;
   } cell_ctrl_type;

endpackage

`default_nettype wire

// ----- design/b2bcd_digit_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none

module b2bcd_digit_cell (
   input  wire logic                     clock,
   input  wire b2bcd_pkg::cell_ctrl_type ctrl,
   input  wire logic                     bit_in,
   output logic                          bit_out,
   output b2bcd_pkg::digit_type          digit
);
   import b2bcd_pkg::*;

   digit_type digit_ff;
   digit_type digit_in;
   digit_type adjusted;

   // add three ahead of the doubling so the digit wraps at ten
   always_comb begin
      if (digit_ff >= DIGIT_BITS'(5)) begin
         adjusted = digit_ff + DIGIT_BITS'(3);
      end else begin
         adjusted = digit_ff;
      end
      if (ctrl.clear) begin
         digit_in = '0;
      end else if (ctrl.shift) begin
         digit_in = {adjusted[DIGIT_BITS-2:0], bit_in};
      end else begin
         digit_in = digit_ff;
      end
   end

   always_ff @(posedge clock) begin
      digit_ff <= digit_in;
   end

   assign bit_out = adjusted[DIGIT_BITS-1];
   assign digit   = digit_ff;

endmodule

`default_nettype wire

// ----- design/binary_to_packed_bcd.sv -----
// an accepted item is shifted bit by bit through the digit cells in CONVERT; in EMIT the bytes
// are registered one byte per cycle while rsp_ready is high, byte_count bytes in all, at most MAX_BYTES
// a new item is accepted only in IDLE, once the last byte of the previous item has been
// registered, since the bit-serial shift through the digit cells keeps the block busy
// a zero byte count gives no bytes and leaves the block idle, ready for a new item in the next cycle
// reset: synchronous, active high; clears the controller and the output valid
`timescale 1ns / 1ps
`default_nettype none

module binary_to_packed_bcd #(
   parameter int VALUE_BITS = 32,
   parameter int MAX_BYTES  = 8
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_ready,
   input  wire logic [VALUE_BITS-1:0]                req_value,
   input  wire logic [b2bcd_pkg::COUNT_BITS-1:0]     req_byte_count,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_ready,
   output logic [b2bcd_pkg::BYTE_BITS-1:0]           rsp_bcd_byte,
   output logic [b2bcd_pkg::INDEX_BITS-1:0]          rsp_byte_index,
   output logic                                      rsp_last
);
   import b2bcd_pkg::*;

   localparam int NUM_DIGITS = 2 * MAX_BYTES;
   localparam int STEP_W     = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;
   localparam int CNT_W      = $clog2(MAX_BYTES + 1);

   typedef enum logic [1:0] {
      IDLE,
      CONVERT,
      EMIT
   } state_type;

   state_type                 state_ff;
   logic [VALUE_BITS-1:0]     value_ff;
   logic [STEP_W-1:0]         step_ff;
   logic [CNT_W-1:0]          count_ff;
   logic [CNT_W-1:0]          ptr_ff;
   logic                      rsp_valid_ff;
   logic                      rsp_valid_in;
   logic [BYTE_BITS-1:0]      rsp_bcd_byte_ff;
   logic [INDEX_BITS-1:0]     rsp_byte_index_ff;
   logic                      rsp_last_ff;

   cell_ctrl_type             ctrl;
   logic                      req_accept;
   logic [CNT_W-1:0]          count_in;
   logic [BYTE_BITS-1:0]      byte_sel;
   logic                      ptr_last;
   logic                      out_free;

   digit_type                 digit [NUM_DIGITS];
   logic [NUM_DIGITS:0]       carry;

   assign req_ready  = (state_ff == IDLE);
   assign req_accept = req_valid && req_ready;
   assign ctrl.clear = req_accept;
   assign ctrl.shift = (state_ff == CONVERT);
   assign carry[0]   = value_ff[VALUE_BITS-1];

   // digit 0 is the least significant; carries climb the row
   for (genvar i = 0; i < NUM_DIGITS; i++) begin : g_cell
      b2bcd_digit_cell u_cell (
         .clock   (clock),
         .ctrl    (ctrl),
         .bit_in  (carry[i]),
         .bit_out (carry[i+1]),
         .digit   (digit[i])
      );
   end

   always_comb begin
      if ({1'b0, req_byte_count} > (COUNT_BITS + 1)'(MAX_BYTES)) begin
         count_in = CNT_W'(MAX_BYTES);
      end else begin
         count_in = CNT_W'(req_byte_count);
      end
   end

   always_comb begin
      byte_sel = '0;
      for (int b = 0; b < MAX_BYTES; b++) begin
         if (ptr_ff == CNT_W'(b)) begin
            byte_sel = {digit[2*b+1], digit[2*b]};
         end
      end
   end

   assign ptr_last = ((ptr_ff + CNT_W'(1)) == count_ff);
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      if ((state_ff == EMIT) && out_free) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         rsp_valid_ff <= 1'b0;
         step_ff      <= '0;
         ptr_ff       <= '0;
         count_ff     <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         case (state_ff)
            IDLE: begin
               if (req_accept && (req_byte_count != '0)) begin
                  state_ff <= CONVERT;
                  count_ff <= count_in;
                  step_ff  <= '0;
                  ptr_ff   <= '0;
               end
            end
            CONVERT: begin
               step_ff <= step_ff + STEP_W'(1);
               if (step_ff == STEP_W'(VALUE_BITS - 1)) begin
                  state_ff <= EMIT;
               end
            end
            EMIT: begin
               if (out_free) begin
                  ptr_ff <= ptr_ff + CNT_W'(1);
                  if (ptr_last) begin
                     state_ff <= IDLE;
                  end
               end
            end
            default: begin
               state_ff <= IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         value_ff <= req_value;
      end else if (state_ff == CONVERT) begin
         value_ff <= {value_ff[VALUE_BITS-2:0], 1'b0};
      end
      if ((state_ff == EMIT) && out_free) begin
         rsp_bcd_byte_ff   <= byte_sel;
         rsp_byte_index_ff <= INDEX_BITS'(ptr_ff);
         rsp_last_ff       <= ptr_last;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_bcd_byte   = rsp_bcd_byte_ff;
   assign rsp_byte_index = rsp_byte_index_ff;
   assign rsp_last       = rsp_last_ff;

   a_zero_count_stays_idle: assert property (@(posedge clock) disable iff (reset)
      (req_accept && (req_byte_count == '0)) |=> (state_ff == IDLE))
      else $error("zero byte count left idle");

   a_accept_starts_convert: assert property (@(posedge clock) disable iff (reset)
      (req_accept && (req_byte_count != '0)) |=> (state_ff == CONVERT))
      else $error("accepted item did not start conversion");

   a_convert_ends: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == CONVERT) && (step_ff == STEP_W'(VALUE_BITS - 1))) |=> (state_ff == EMIT))
      else $error("conversion did not end after all bits");

   a_ptr_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == EMIT) |-> ((ptr_ff < count_ff) && (count_ff != '0)))
      else $error("byte pointer out of range");

   a_last_ends_emit: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == EMIT) && out_free && ptr_last) |=> (rsp_valid_ff && rsp_last_ff))
      else $error("final byte not marked last");

endmodule

`default_nettype wire
